@@ design/circular_doubly_linked_list_engine_core_macros.svh @@
// Assertion macros for the circular doubly linked list engine.
// Clock clk and active-low reset rst_n are taken from the enclosing module.
`ifndef CIRCULAR_DOUBLY_LINKED_LIST_ENGINE_CORE_MACROS_SVH
`define CIRCULAR_DOUBLY_LINKED_LIST_ENGINE_CORE_MACROS_SVH

// same-cycle implication
`define CDLL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CDLL_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/cdll_pkg.sv @@
// Shared types and constants for the circular doubly linked list engine.
// No dependencies; used by cdll_ctrl, cdll_dp and the top level.
`default_nettype none

package cdll_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int VALUE_W      = 32;
  localparam int FUNC_W       = 3;
  localparam int ST_W         = 2;
  localparam int CNT_W        = 5;
  localparam int IN_TDATA_W   = 32;
  localparam int OUT_TDATA_W  = 40;

  localparam logic [FUNC_W-1:0] FN_FRONT = 3'd0;
  localparam logic [FUNC_W-1:0] FN_BACK  = 3'd1;
  localparam logic [FUNC_W-1:0] FN_SORT  = 3'd2;
  localparam logic [FUNC_W-1:0] FN_DEL   = 3'd3;
  localparam logic [FUNC_W-1:0] FN_READ  = 3'd4;

  typedef enum logic [ST_W-1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_MISSING = 2'd3
  } st_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DISP, S_HCHK, S_WCHK, S_LINK1, S_LINK2, S_DCHK, S_RDAT, S_EMIT
  } fsm_t;

  typedef enum logic [3:0] {
    DP_NONE, DP_CAPTURE, DP_SOLO, DP_START, DP_FB, DP_WSTART, DP_WSTEP,
    DP_BRK, DP_BRK_END, DP_BRK_HEAD, DP_LINK1, DP_LINK2, DP_DEL, DP_STEP
  } dp_op_t;

  typedef enum logic [1:0] {
    RA_HEAD, RA_NRD, RA_CUR
  } rd_sel_t;

  typedef struct packed {
    dp_op_t  op;
    rd_sel_t rd_sel;
    logic    out_load;
    logic    out_elem;
    logic    out_last;
    st_t     out_st;
  } cmd_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              cnt_zero;
    logic              full;
    logic              vrd_lt;
    logic              vrd_eq;
    logic              nrd_is_head;
    logic              idx_last;
    logic              out_free;
  } stat_t;

endpackage

`default_nettype wire

@@ design/cdll_dp.sv @@
// Datapath: node pool memories, valid bits, head, count, walk registers, output register.
// Depends on cdll_pkg; driven by commands from cdll_ctrl.
`default_nettype none

module cdll_dp
  import cdll_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire cmd_t                          cmd,
  output stat_t                              stat,
  input  wire logic [FUNC_W-1:0]             in_func,
  input  wire logic signed [VALUE_W-1:0]     in_value,
  input  wire logic                          out_ready,
  output logic                               out_valid,
  output st_t                                out_st,
  output logic signed [VALUE_W-1:0]          out_elem,
  output logic                               out_last,
  output logic [CNT_W-1:0]                   out_cnt
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  logic signed [VALUE_W-1:0] mem_val [CAPACITY];
  logic [IW-1:0]             mem_nxt [CAPACITY];
  logic [IW-1:0]             mem_prv [CAPACITY];

  logic [CAPACITY-1:0]       valid_r, valid_nxt;
  logic [IW-1:0]             head_r, head_nxt;
  logic [CW-1:0]             cnt_r, cnt_nxt;
  logic [FUNC_W-1:0]         func_r;
  logic signed [VALUE_W-1:0] v_r;
  logic [IW-1:0]             n_r, cur_r, nx_r, p_r, s_r;
  logic [CW-1:0]             idx_r;
  logic                      front_r;

  logic signed [VALUE_W-1:0] vrd_r;
  logic [IW-1:0]             nrd_r, prd_r;
  logic [IW-1:0]             rd_addr;
  logic [IW-1:0]             free_idx;

  logic                      val_we, nxt_we, prv_we;
  logic [IW-1:0]             val_wa, nxt_wa, prv_wa, nxt_wd, prv_wd;

  logic                      out_valid_r;
  st_t                       out_st_r;
  logic signed [VALUE_W-1:0] out_elem_r;
  logic                      out_last_r;
  logic [CNT_W-1:0]          out_cnt_r;
  logic [31:0]               cnt_ext;

  // lowest free pool entry
  always_comb begin
    free_idx = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (!valid_r[i]) free_idx = IW'(i);
    end
  end

  always_comb begin
    case (cmd.rd_sel)
      RA_HEAD: rd_addr = head_r;
      RA_NRD:  rd_addr = nrd_r;
      RA_CUR:  rd_addr = cur_r;
      default: rd_addr = head_r;
    endcase
  end

  // memory write ports
  always_comb begin
    val_we = 1'b0; val_wa = n_r;
    nxt_we = 1'b0; nxt_wa = n_r; nxt_wd = n_r;
    prv_we = 1'b0; prv_wa = n_r; prv_wd = n_r;
    case (cmd.op)
      DP_SOLO: begin
        val_we = 1'b1;
        nxt_we = 1'b1;
        prv_we = 1'b1;
      end
      DP_LINK1: begin
        val_we = 1'b1;
        nxt_we = 1'b1; nxt_wd = s_r;
        prv_we = 1'b1; prv_wd = p_r;
      end
      DP_LINK2: begin
        nxt_we = 1'b1; nxt_wa = p_r;
        prv_we = 1'b1; prv_wa = s_r;
      end
      DP_DEL: begin
        if (nrd_r != cur_r) begin
          nxt_we = 1'b1; nxt_wa = prd_r; nxt_wd = nrd_r;
          prv_we = 1'b1; prv_wa = nrd_r; prv_wd = prd_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (val_we) mem_val[val_wa] <= v_r;
    vrd_r <= mem_val[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (nxt_we) mem_nxt[nxt_wa] <= nxt_wd;
    nrd_r <= mem_nxt[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (prv_we) mem_prv[prv_wa] <= prv_wd;
    prd_r <= mem_prv[rd_addr];
  end

  // list control state
  always_comb begin
    valid_nxt = valid_r;
    head_nxt  = head_r;
    cnt_nxt   = cnt_r;
    case (cmd.op)
      DP_SOLO: begin
        valid_nxt[n_r] = 1'b1;
        head_nxt       = n_r;
        cnt_nxt        = CW'(cnt_r + CW'(1));
      end
      DP_LINK1: begin
        valid_nxt[n_r] = 1'b1;
        cnt_nxt        = CW'(cnt_r + CW'(1));
      end
      DP_LINK2: begin
        if (front_r) head_nxt = n_r;
      end
      DP_DEL: begin
        valid_nxt[cur_r] = 1'b0;
        if (nrd_r == cur_r) begin
          head_nxt = '0;
          cnt_nxt  = '0;
        end else begin
          if (cur_r == head_r) head_nxt = nrd_r;
          cnt_nxt = CW'(cnt_r - CW'(1));
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      head_r  <= '0;
      cnt_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      head_r  <= head_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // walk and request registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      DP_CAPTURE: begin
        func_r <= in_func;
        v_r    <= in_value;
        n_r    <= free_idx;
      end
      DP_START: begin
        cur_r <= head_r;
        idx_r <= '0;
      end
      DP_FB: begin
        p_r     <= prd_r;
        s_r     <= head_r;
        front_r <= (func_r != FN_BACK);
      end
      DP_WSTART: begin
        cur_r <= head_r;
        nx_r  <= nrd_r;
      end
      DP_WSTEP: begin
        cur_r <= nx_r;
        nx_r  <= nrd_r;
      end
      DP_BRK: begin
        p_r     <= cur_r;
        s_r     <= nx_r;
        front_r <= 1'b0;
      end
      DP_BRK_END: begin
        p_r     <= nx_r;
        s_r     <= nrd_r;
        front_r <= 1'b0;
      end
      DP_BRK_HEAD: begin
        p_r     <= head_r;
        s_r     <= nrd_r;
        front_r <= 1'b0;
      end
      DP_STEP: begin
        cur_r <= nrd_r;
        idx_r <= CW'(idx_r + CW'(1));
      end
      default: ;
    endcase
  end

  // output register
  assign cnt_ext = 32'(cnt_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_st_r   <= cmd.out_st;
      out_elem_r <= cmd.out_elem ? vrd_r : '0;
      out_last_r <= cmd.out_last;
      out_cnt_r  <= cnt_ext[CNT_W-1:0];
    end
  end

  assign out_valid = out_valid_r;
  assign out_st    = out_st_r;
  assign out_elem  = out_elem_r;
  assign out_last  = out_last_r;
  assign out_cnt   = out_cnt_r;

  assign stat.func        = func_r;
  assign stat.cnt_zero    = (cnt_r == '0);
  assign stat.full        = &valid_r;
  assign stat.vrd_lt      = (vrd_r < v_r);
  assign stat.vrd_eq      = (vrd_r == v_r);
  assign stat.nrd_is_head = (nrd_r == head_r);
  assign stat.idx_last    = (CW'(idx_r + CW'(1)) == cnt_r);
  assign stat.out_free    = !out_valid_r || out_ready;

endmodule

`default_nettype wire

@@ design/cdll_ctrl.sv @@
// Controller state machine: sequences each request over the datapath.
// Depends on cdll_pkg; talks to cdll_dp through cmd_t and stat_t.
`default_nettype none

module cdll_ctrl
  import cdll_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  wire stat_t stat,
  output cmd_t       cmd
);

  fsm_t state_r, state_nxt;
  st_t  st_r, st_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      st_r    <= ST_OK;
    end else begin
      state_r <= state_nxt;
      st_r    <= st_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_DISP;
      S_DISP: begin
        if (stat.func inside {FN_FRONT, FN_BACK, FN_SORT}) begin
          if (stat.full || stat.cnt_zero) state_nxt = S_EMIT;
          else                             state_nxt = S_HCHK;
        end else if (stat.func == FN_DEL) begin
          state_nxt = stat.cnt_zero ? S_EMIT : S_DCHK;
        end else if (stat.func == FN_READ) begin
          state_nxt = stat.cnt_zero ? S_EMIT : S_RDAT;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_HCHK: begin
        if (stat.func == FN_SORT && stat.vrd_lt && !stat.nrd_is_head) state_nxt = S_WCHK;
        else                                                         state_nxt = S_LINK1;
      end
      S_WCHK: if (!stat.vrd_lt || stat.nrd_is_head) state_nxt = S_LINK1;
      S_LINK1: state_nxt = S_LINK2;
      S_LINK2: state_nxt = S_EMIT;
      S_DCHK:  if (stat.vrd_eq || stat.idx_last) state_nxt = S_EMIT;
      S_RDAT:  if (stat.out_free && stat.idx_last) state_nxt = S_IDLE;
      S_EMIT:  if (stat.out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd          = '{op: DP_NONE, rd_sel: RA_HEAD, out_load: 1'b0, out_elem: 1'b0,
                     out_last: 1'b1, out_st: st_r};
    st_nxt       = st_r;
    in_ready     = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) cmd.op = DP_CAPTURE;
      end
      S_DISP: begin
        st_nxt = ST_OK;
        if (stat.func inside {FN_FRONT, FN_BACK, FN_SORT}) begin
          if (stat.full)          st_nxt = ST_FULL;
          else if (stat.cnt_zero) cmd.op = DP_SOLO;
        end else if (stat.func == FN_DEL || stat.func == FN_READ) begin
          if (stat.cnt_zero) st_nxt = ST_EMPTY;
          else               cmd.op = DP_START;
        end
      end
      S_HCHK: begin
        if (stat.func == FN_SORT && stat.vrd_lt) begin
          if (stat.nrd_is_head) begin
            cmd.op = DP_BRK_HEAD;
          end else begin
            cmd.op     = DP_WSTART;
            cmd.rd_sel = RA_NRD;
          end
        end else begin
          cmd.op = DP_FB;
        end
      end
      S_WCHK: begin
        if (!stat.vrd_lt) begin
          cmd.op = DP_BRK;
        end else if (stat.nrd_is_head) begin
          cmd.op = DP_BRK_END;
        end else begin
          cmd.op     = DP_WSTEP;
          cmd.rd_sel = RA_NRD;
        end
      end
      S_LINK1: cmd.op = DP_LINK1;
      S_LINK2: begin
        cmd.op = DP_LINK2;
        st_nxt = ST_OK;
      end
      S_DCHK: begin
        if (stat.vrd_eq) begin
          cmd.op = DP_DEL;
          st_nxt = ST_OK;
        end else if (stat.idx_last) begin
          st_nxt = ST_MISSING;
        end else begin
          cmd.op     = DP_STEP;
          cmd.rd_sel = RA_NRD;
        end
      end
      S_RDAT: begin
        if (stat.out_free) begin
          cmd.op       = DP_STEP;
          cmd.rd_sel   = RA_NRD;
          cmd.out_load = 1'b1;
          cmd.out_elem = 1'b1;
          cmd.out_last = stat.idx_last;
          cmd.out_st   = ST_OK;
        end else begin
          // hold the current element on the read port
          cmd.rd_sel = RA_CUR;
        end
      end
      S_EMIT: cmd.out_load = stat.out_free;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

@@ design/circular_doubly_linked_list_engine_core.sv @@
// Circular doubly linked list engine over a pool of CAPACITY nodes. One request is
// worked at a time; in_tready is high only between requests. An insert into an empty
// list or a full pool, an unused code, or a delete or read out of an empty list goes
// from dispatch straight to the result; insert front or back links the node in the
// link states; a sorted insert first walks nodes past the head; a delete compares
// nodes in turn; a read out gives one element per cycle while the output is free.
// The walks use the single read port of the node value and link memories, one linked
// node per cycle. Output stalls hold the read out between elements and hold every
// other request in its final state until the output register frees; one finished
// result may wait in the output register while the next request is accepted.
`default_nettype none

`include "circular_doubly_linked_list_engine_core_macros.svh"

module circular_doubly_linked_list_engine_core
  import cdll_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,   // [31:0] value
  input  wire logic [FUNC_W-1:0]      in_tuser,   // [2:0] func
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata,  // [31:0] element, [36:32] count, rest zero
  output logic [ST_W-1:0]             out_tuser,  // [1:0] status
  output logic                        out_tlast
);

  cmd_t                      cmd;
  stat_t                     stat;
  st_t                       out_st;
  logic signed [VALUE_W-1:0] out_elem;
  logic [CNT_W-1:0]          out_cnt;

  cdll_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  cdll_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_func   (in_tuser),
    .in_value  (in_tdata[VALUE_W-1:0]),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .out_st    (out_st),
    .out_elem  (out_elem),
    .out_last  (out_tlast),
    .out_cnt   (out_cnt)
  );

  assign out_tdata = {{(OUT_TDATA_W - VALUE_W - CNT_W){1'b0}}, out_cnt, out_elem};
  assign out_tuser = out_st;

  `CDLL_ASSERT_NXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready, "accept while busy")
  `CDLL_ASSERT_IMP(a_partial_ok, out_tvalid && !out_tlast, out_tuser == ST_OK, "bad mid status")
  `CDLL_ASSERT_IMP(a_full_count, out_tvalid && out_tuser == ST_FULL, out_cnt == CNT_W'(CAPACITY), "full but count short")
  `CDLL_ASSERT_IMP(a_empty_count, out_tvalid && out_tuser == ST_EMPTY, out_cnt == '0, "empty but count set")

endmodule

`default_nettype wire

@@ dv/cdll_scoreboard.sv @@
// List checker for the circular doubly linked list engine: watches both streams,
// keeps its own copy of the node pool and compares each output item.
// Depends on cdll_pkg.
module cdll_scoreboard
  import cdll_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic [FUNC_W-1:0]      in_tuser,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic [ST_W-1:0]        out_tuser,
  input  logic                   out_tlast,
  output int                     err_cnt,
  output int                     pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    st_t              st;
    logic [31:0]      elem;
    logic             lst;
    logic [CNT_W-1:0] cnt;
  } list_res_t;

  logic [31:0] pool_val [CAPACITY];
  int          nxt [CAPACITY];
  int          prv [CAPACITY];
  bit          used [CAPACITY];
  int          head;
  int          size;
  list_res_t   want_q [$];

  assign pending = want_q.size();

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] exp);
    $display("%0t mismatch %s: got %0h expected %0h", $time, what, got, exp);
    err_cnt++;
  endtask

  function automatic void push_res(st_t st, logic [31:0] e, logic l);
    list_res_t r;
    r.st = st; r.elem = e; r.lst = l; r.cnt = size[CNT_W-1:0];
    want_q.push_back(r);
  endfunction

  function automatic void splice_after(int p, int n);
    int s;
    s = nxt[p];
    nxt[n] = s; prv[n] = p; prv[s] = n; nxt[p] = n;
  endfunction

  function automatic void predict_list(logic [FUNC_W-1:0] fn, logic [31:0] v);
    int free_ix, cur, steps;
    bit hit;
    free_ix = CAPACITY;
    if (fn == FN_FRONT || fn == FN_BACK || fn == FN_SORT) begin
      for (int i = CAPACITY - 1; i >= 0; i--) if (!used[i]) free_ix = i;
      if (free_ix == CAPACITY) begin
        push_res(ST_FULL, '0, 1'b1);
        return;
      end
      pool_val[free_ix] = v;
      used[free_ix] = 1'b1;
      if (size == 0) begin
        nxt[free_ix] = free_ix; prv[free_ix] = free_ix; head = free_ix;
      end else if (fn == FN_SORT && $signed(pool_val[head]) < $signed(v)) begin
        cur = head;
        for (steps = 0; steps < CAPACITY; steps++) begin
          if (nxt[cur] == head || !($signed(pool_val[nxt[cur]]) < $signed(v))) break;
          cur = nxt[cur];
        end
        splice_after(cur, free_ix);
      end else begin
        splice_after(prv[head], free_ix);
        if (fn != FN_BACK) head = free_ix;
      end
      size++;
      push_res(ST_OK, '0, 1'b1);
    end else if (fn == FN_DEL) begin
      if (size == 0) begin
        push_res(ST_EMPTY, '0, 1'b1);
        return;
      end
      cur = head;
      hit = 1'b0;
      for (steps = 0; steps < size && !hit; steps++) begin
        if (pool_val[cur] == v) begin
          hit = 1'b1;
          used[cur] = 1'b0;
          if (nxt[cur] == cur) begin
            head = 0; size = 0;
          end else begin
            nxt[prv[cur]] = nxt[cur];
            prv[nxt[cur]] = prv[cur];
            if (cur == head) head = nxt[cur];
            size--;
          end
        end else begin
          cur = nxt[cur];
        end
      end
      push_res(hit ? ST_OK : ST_MISSING, '0, 1'b1);
    end else if (fn == FN_READ) begin
      if (size == 0) begin
        push_res(ST_EMPTY, '0, 1'b1);
        return;
      end
      cur = head;
      for (int k = 0; k < size; k++) begin
        push_res(ST_OK, pool_val[cur], k == size - 1);
        cur = nxt[cur];
      end
    end else begin
      push_res(ST_OK, '0, 1'b1);
    end
  endfunction

  initial begin
    err_cnt = 0;
    head = 0;
    size = 0;
    foreach (used[i]) used[i] = 1'b0;
  end

  always @(posedge clk) begin
    list_res_t w;
    if (rst_n && out_tvalid && out_tready) begin
      if (want_q.size() == 0) begin
        report("unexpected item", out_tdata, 0);
      end else begin
        w = want_q.pop_front();
        if (out_tuser !== w.st) report("status", out_tuser, w.st);
        if (out_tdata[31:0] !== w.elem) report("element", out_tdata[31:0], w.elem);
        if (out_tdata[36:32] !== w.cnt) report("count", out_tdata[36:32], w.cnt);
        if (out_tdata[39:37] !== 3'b000) report("pad bits", out_tdata[39:37], 0);
        if (out_tlast !== w.lst) report("last", out_tlast, w.lst);
      end
    end
    if (rst_n && in_tvalid && in_tready) predict_list(in_tuser, in_tdata);
  end
endmodule

@@ dv/tb_circular_doubly_linked_list_engine_core.sv @@
// Stimulus and verdict for the circular doubly linked list engine.
// Depends on cdll_pkg, the engine RTL and cdll_scoreboard.
module tb_circular_doubly_linked_list_engine_core;
  import cdll_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic [FUNC_W-1:0]      in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [ST_W-1:0]        out_tuser;
  logic                   out_tlast;
  int                     err_cnt;
  int                     pending;
  bit                     calm;
  logic [31:0]            recent [8];

  circular_doubly_linked_list_engine_core u_dut (.*);

  cdll_scoreboard u_sb (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // sink: random stall except during calm stretch
  always @(negedge clk) out_tready <= calm || ($urandom_range(99) >= 24);

  task automatic send_item(input logic [FUNC_W-1:0] fn, input logic [31:0] v);
    while (!calm && $urandom_range(99) < 24) @(negedge clk);
    in_tvalid = 1'b1;
    in_tuser  = fn;
    in_tdata  = v;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    in_tvalid = 1'b0;
    recent[$urandom_range(7)] = v;
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom();
      3, 4: return recent[$urandom_range(7)];
      default: return 32'($signed($urandom_range(40)) - 20);
    endcase
  endfunction

  function automatic logic [FUNC_W-1:0] pick_func();
    int r;
    r = $urandom_range(99);
    if (r < 18) return FN_FRONT;
    if (r < 34) return FN_BACK;
    if (r < 58) return FN_SORT;
    if (r < 80) return FN_DEL;
    if (r < 96) return FN_READ;
    return FUNC_W'($urandom_range(7, 5));
  endfunction

  initial begin
    foreach (recent[i]) recent[i] = $urandom_range(9);
    rst_n = 1'b0; in_tvalid = 1'b0; in_tdata = '0; in_tuser = FN_FRONT;
    out_tready = 1'b0; calm = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    // directed: empty cases, extremes, sorted order, fill past capacity, all codes
    send_item(FN_READ, 0);
    send_item(FN_DEL, 5);
    send_item(FN_SORT, 32'd10);
    send_item(FN_SORT, 32'h8000_0000);
    send_item(FN_SORT, 32'h7fff_ffff);
    send_item(FN_SORT, 32'd10);
    send_item(FN_SORT, 32'hffff_ffff);
    send_item(FN_READ, 0);
    send_item(FN_DEL, 32'd77);
    send_item(FN_DEL, 32'h8000_0000);
    for (int i = 0; i < 13; i++) send_item(i[0] ? FN_BACK : FN_FRONT, $urandom());
    send_item(FN_SORT, 32'd3);
    send_item(FN_READ, 0);
    for (int k = 5; k < 8; k++) send_item(FUNC_W'(k), $urandom());
    // pause until the engine drains
    while (pending != 0) @(negedge clk);
    for (int i = 0; i < 480; i++) begin
      calm = (i >= 200 && i < 260);
      if (i % 60 == 30) begin
        // delete a recently sent value to revisit empty and head cases
        send_item(FN_DEL, recent[0]);
      end
      send_item(pick_func(), pick_value());
    end
    calm = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("DONE: errors detected");
    $finish;
  end
endmodule
